### hdl/iqpd_pkg.sv
package iqpd_pkg;

  localparam int RawWidth = 32;
  localparam int FieldWidth = 14;
  localparam int HalfWidth = 16;
  localparam int DecimWidth = 16;
  localparam int IMarkBit = 21;
  localparam logic [DecimWidth-1:0] DecimReset = 16'd1;

  typedef struct packed {
    logic [RawWidth-1:0] raw_word;
    logic                first_of_block;
    logic                last_of_block;
  } in_item_t;

  typedef struct packed {
    logic [RawWidth-1:0] packed_sample;
    logic                sample_valid;
    logic                block_end;
  } out_item_t;

  function automatic logic [HalfWidth-1:0] widen14(input logic [FieldWidth-1:0] v);
    widen14 = {{(HalfWidth - FieldWidth){v[FieldWidth-1]}}, v};
  endfunction

endpackage

### hdl/iqpd_pair.sv
module iqpd_pair (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  iqpd_pkg::in_item_t                  in_item,
  input  logic                                cfg_write,
  input  logic [iqpd_pkg::DecimWidth-1:0]     cfg_value,
  output logic                                res_valid,
  output iqpd_pkg::out_item_t                 res_item
);

  logic                                expect_q;
  logic                                expect_q_next;
  logic [iqpd_pkg::FieldWidth-1:0]     held_i;
  logic [iqpd_pkg::FieldWidth-1:0]     held_i_next;
  logic [iqpd_pkg::DecimWidth-1:0]     pair_count;
  logic [iqpd_pkg::DecimWidth-1:0]     pair_count_next;
  logic [iqpd_pkg::DecimWidth-1:0]     decimation;
  logic [iqpd_pkg::DecimWidth-1:0]     factor;
  logic [iqpd_pkg::DecimWidth-1:0]     count_now;
  logic [iqpd_pkg::DecimWidth:0]       count_inc;
  logic                                expect_now;
  logic                                dropped;
  logic                                emit;

  always_comb begin
    factor = (decimation == '0) ? iqpd_pkg::DecimWidth'(1) : decimation;
    expect_now = in_item.first_of_block ? 1'b0 : expect_q;
    count_now = in_item.first_of_block ? '0 : pair_count;
    count_inc = {1'b0, count_now} + (iqpd_pkg::DecimWidth + 1)'(1);
    dropped = in_item.first_of_block && !in_item.raw_word[iqpd_pkg::IMarkBit];
    emit = 1'b0;
    expect_q_next = expect_now;
    held_i_next = held_i;
    pair_count_next = count_now;
    if (!dropped) begin
      if (!expect_now) begin
        held_i_next = in_item.raw_word[iqpd_pkg::FieldWidth-1:0];
        expect_q_next = 1'b1;
      end else begin
        expect_q_next = 1'b0;
        emit = (count_now == '0);
        if (count_inc >= {1'b0, factor}) begin
          pair_count_next = '0;
        end else begin
          pair_count_next = count_inc[iqpd_pkg::DecimWidth-1:0];
        end
      end
    end
    if (in_item.last_of_block) begin
      expect_q_next = 1'b0;
      pair_count_next = '0;
    end
    res_valid = emit || in_item.last_of_block;
    res_item.sample_valid = emit;
    res_item.block_end = in_item.last_of_block;
    res_item.packed_sample = emit ?
        {iqpd_pkg::widen14(held_i),
         iqpd_pkg::widen14(in_item.raw_word[iqpd_pkg::FieldWidth-1:0])} : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_q <= 1'b0;
      held_i <= '0;
      pair_count <= '0;
      decimation <= iqpd_pkg::DecimReset;
    end else begin
      if (accept) begin
        expect_q <= expect_q_next;
        held_i <= held_i_next;
        pair_count <= pair_count_next;
      end
      if (cfg_write) begin
        decimation <= cfg_value;
      end
    end
  end

endmodule

### hdl/iqpd_out.sv
module iqpd_out (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 res_valid,
  input  iqpd_pkg::out_item_t  res_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output iqpd_pkg::out_item_t  out_data
);

  logic load;

  assign in_ready = !out_valid || out_ready;
  assign load = in_valid && in_ready && res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res_item;
    end
  end

endmodule

### hdl/iq_sample_pack_decimate.sv
// Channel  Direction  Payload                                    Transfer when
// in       input      raw_word, first_of_block, last_of_block    in_valid && in_ready
// out      output     packed_sample, sample_valid, block_end     out_valid && out_ready
// cfg      input      decimation (16 bit)                        cfg_valid && cfg_ready
//
// One input word is taken every cycle while in_ready is high; any result it gives appears in the cycle after.
// The pairing state and the result register are the only pipeline stages.
// A stalled result holds in_ready low until it is taken; cfg is always ready.
// Synchronous reset clears pairing state, sets decimation to one, empties output.
module iq_sample_pack_decimate (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  iqpd_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output iqpd_pkg::out_item_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [iqpd_pkg::DecimWidth-1:0]  cfg_data
);

  logic                 accept;
  logic                 res_valid;
  iqpd_pkg::out_item_t  res_item;

  assign cfg_ready = 1'b1;
  assign accept = in_valid && in_ready;

  iqpd_pair u_pair (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_item   (in_data),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_value (cfg_data),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  iqpd_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .res_valid (res_valid),
    .res_item  (res_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  a_last_gives_end: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.last_of_block |=> out_valid && out_data.block_end)
    else $error("Last word of a block did not produce a block end result.");

  a_empty_is_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.sample_valid |-> out_data.block_end && out_data.packed_sample == '0)
    else $error("Result without a sample is not a clean block end.");

  a_leading_q_dropped: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.first_of_block && !in_data.raw_word[iqpd_pkg::IMarkBit] &&
    !in_data.last_of_block |=> !out_valid)
    else $error("Dropped leading word produced a result.");

  a_first_i_no_result: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.first_of_block && !in_data.last_of_block |=> !out_valid)
    else $error("First word of a block produced a result.");
`endif

endmodule

### dv/tb_iq_sample_pack_decimate.sv
module tb_iq_sample_pack_decimate;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QuietLimit = 2000;
  localparam int PhaseWords = 120;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  iqpd_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  iqpd_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [iqpd_pkg::DecimWidth-1:0] cfg_data = '0;

  iq_sample_pack_decimate dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Packer state as the block should hold it.
  logic [iqpd_pkg::DecimWidth-1:0] decim_factor = iqpd_pkg::DecimReset;
  bit want_q = 1'b0;
  logic [iqpd_pkg::FieldWidth-1:0] held_i = '0;
  logic [15:0] pair_pos = '0;

  iqpd_pkg::out_item_t pending_packets[$];
  int errors = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int quiet = 0;
  logic [7:0] stall_tick = '0;
  logic [15:0] stall_mask = 16'hffff;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic bit step_packer(input iqpd_pkg::in_item_t w,
                                     output iqpd_pkg::out_item_t r);
    bit emit;
    bit drop;
    int unsigned factor;
    logic signed [15:0] i16;
    logic signed [15:0] q16;
    emit = 1'b0;
    drop = 1'b0;
    i16 = '0;
    q16 = '0;
    factor = (decim_factor == 0) ? 1 : int'(decim_factor);
    if (w.first_of_block) begin
      want_q = 1'b0;
      pair_pos = '0;
      drop = !w.raw_word[iqpd_pkg::IMarkBit];
    end
    if (!drop) begin
      if (!want_q) begin
        held_i = w.raw_word[iqpd_pkg::FieldWidth-1:0];
        want_q = 1'b1;
      end else begin
        want_q = 1'b0;
        if (pair_pos == 0) begin
          emit = 1'b1;
          i16 = $signed(held_i);
          q16 = $signed(w.raw_word[iqpd_pkg::FieldWidth-1:0]);
        end
        if (int'(pair_pos) + 1 >= factor) pair_pos = '0;
        else pair_pos = pair_pos + 16'd1;
      end
    end
    if (w.last_of_block) begin
      want_q = 1'b0;
      pair_pos = '0;
    end
    r.packed_sample = emit ? {i16, q16} : '0;
    r.sample_valid = emit;
    r.block_end = w.last_of_block;
    return emit || w.last_of_block;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < 40) begin
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    end
    errors++;
  endtask

  always @(posedge clk) begin
    iqpd_pkg::out_item_t exp_pkt;
    stall_tick <= stall_tick + 8'd1;
    if (stall_tick == 8'd0) begin
      stall_mask <= ($urandom_range(0, 2) == 0) ? 16'hffff : (16'($urandom) | 16'h0001);
    end
    out_ready <= stall_mask[stall_tick[3:0]];
    if (!rst && out_valid && out_ready) begin
      if (pending_packets.size() == 0) begin
        report_mismatch("unexpected result", out_data.packed_sample, '0);
      end else begin
        exp_pkt = pending_packets.pop_front();
        if (out_data.packed_sample !== exp_pkt.packed_sample) begin
          report_mismatch("packed_sample", out_data.packed_sample, exp_pkt.packed_sample);
        end
        if (out_data.sample_valid !== exp_pkt.sample_valid) begin
          report_mismatch("sample_valid", 32'(out_data.sample_valid),
                          32'(exp_pkt.sample_valid));
        end
        if (out_data.block_end !== exp_pkt.block_end) begin
          report_mismatch("block_end", 32'(out_data.block_end), 32'(exp_pkt.block_end));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QuietLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_word(input logic [31:0] raw, input bit is_first, input bit is_last);
    iqpd_pkg::in_item_t w;
    iqpd_pkg::out_item_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on && $urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
    end
    burst_left--;
    w.raw_word = raw;
    w.first_of_block = is_first;
    w.last_of_block = is_last;
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (step_packer(w, r)) pending_packets.push_back(r);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_packets.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_decimation(input logic [iqpd_pkg::DecimWidth-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    decim_factor = value;
  endtask

  function automatic logic [31:0] rand_word(input bit i_mark);
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 7))
      0: w[iqpd_pkg::FieldWidth-1:0] = 14'h1fff;
      1: w[iqpd_pkg::FieldWidth-1:0] = 14'h2000;
      2: w[iqpd_pkg::FieldWidth-1:0] = 14'h3fff;
      3: w[iqpd_pkg::FieldWidth-1:0] = 14'h0000;
      default: ;
    endcase
    w[iqpd_pkg::IMarkBit] = i_mark;
    return w;
  endfunction

  task automatic send_random_block(inout int words_sent);
    int kind;
    int len;
    bit noise;
    bit lead_q;
    bit odd;
    bit open_end;
    kind = $urandom_range(0, 9);
    noise = (kind == 9);
    lead_q = (kind == 6);
    odd = (kind == 7);
    open_end = (kind == 8);
    len = ($urandom_range(0, 3) == 0) ? 2 * $urandom_range(1, 3) : 2 * $urandom_range(1, 12);
    if (odd) len = len + 1;
    if (lead_q) send_word(rand_word(1'b0), 1'b1, 1'b0);
    for (int k = 0; k < len; k++) begin
      if (noise) begin
        send_word(rand_word(1'($urandom_range(0, 1))), $urandom_range(0, 7) == 0,
                  $urandom_range(0, 7) == 0);
      end else begin
        send_word(rand_word(k % 2 == 0), (k == 0) && !lead_q,
                  (k == len - 1) && !open_end);
      end
    end
    words_sent += len + (lead_q ? 1 : 0);
  endtask

  task automatic test_pairing_corners;
    send_word(32'h0000_1fff, 1'b1, 1'b0);
    send_word(32'h0020_1fff, 1'b0, 1'b0);
    send_word(32'h0000_2000, 1'b0, 1'b0);
    send_word(32'hffff_ffff, 1'b1, 1'b0);
    send_word(32'hffdf_c000, 1'b0, 1'b0);
    send_word(32'h0000_0000, 1'b0, 1'b0);
    send_word(32'h0020_3fff, 1'b0, 1'b0);
    send_word(32'h0020_1234, 1'b0, 1'b1);
    send_word(32'h0020_0001, 1'b1, 1'b1);
    send_word(32'h0000_0001, 1'b1, 1'b1);
    send_word(32'h0020_0abc, 1'b1, 1'b0);
    send_word(32'h0000_2abc, 1'b0, 1'b1);
    send_word(32'h0020_0005, 1'b0, 1'b0);
    send_word(32'h0020_0007, 1'b1, 1'b0);
    send_word(32'h0000_0009, 1'b0, 1'b0);
    send_word(32'h0020_0100, 1'b0, 1'b0);
    send_word(32'h0000_3333, 1'b1, 1'b0);
    send_word(32'h0020_0011, 1'b0, 1'b0);
    send_word(32'hffdf_e001, 1'b0, 1'b1);
    send_word(32'h0020_2000, 1'b1, 1'b0);
    send_word(32'h0020_1fff, 1'b0, 1'b0);
  endtask

  task automatic test_decimation_sweep;
    logic [iqpd_pkg::DecimWidth-1:0] factors[9];
    int words_sent;
    factors = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd7, 16'hffff, 16'd1, 16'd5, 16'd0};
    factors[6] = 16'($urandom_range(4, 16));
    factors[7] = 16'($urandom_range(0, 65535));
    foreach (factors[p]) begin
      write_decimation(factors[p]);
      gaps_on = (p % 3 != 1);
      words_sent = 0;
      while (words_sent < PhaseWords) send_random_block(words_sent);
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_decimation_change_mid_block;
    write_decimation(16'd5);
    send_word(rand_word(1'b1), 1'b1, 1'b0);
    send_word(rand_word(1'b0), 1'b0, 1'b0);
    for (int k = 0; k < 6; k++) send_word(rand_word(k % 2 == 0), 1'b0, 1'b0);
    write_decimation(16'd3);
    for (int k = 0; k < 8; k++) send_word(rand_word(k % 2 == 0), 1'b0, 1'b0);
    write_decimation(16'd2);
    for (int k = 0; k < 6; k++) send_word(rand_word(k % 2 == 0), 1'b0, k == 5);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_pairing_corners();
    test_decimation_sweep();
    test_decimation_change_mid_block();
    drain();
    if (errors == 0 && pending_packets.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
